[rtl/mhnl_pkg.sv]
// Shared types and constants for the MIDI held-note list.
package mhnl_pkg;

    // MIDI status bytes recognised while idle.
    localparam logic [7:0] STATUS_NOTE_ON  = 8'h90;
    localparam logic [7:0] STATUS_NOTE_OFF = 8'h80;

    // Event codes reported with each result beat.
    typedef logic [2:0] t_event;

    localparam t_event EV_NONE      = 3'd0;
    localparam t_event EV_ADDED     = 3'd1;
    localparam t_event EV_DROPPED   = 3'd2;
    localparam t_event EV_REMOVED   = 3'd3;
    localparam t_event EV_NOT_FOUND = 3'd4;

    // One list entry: velocity in the upper byte, key in the lower byte.
    typedef struct packed {
        logic [7:0] velocity;
        logic [7:0] key;
    } t_entry;

endpackage

[rtl/midi_held_note_list_core.sv]
// MIDI note-on / note-off tracker keeping an ordered list of held notes.
//
// Input channel: a received MIDI byte on i_rx_byte is taken at a rising edge
// where start is high and busy is low. Every byte produces exactly one result
// beat, marked by o_strobe for a single cycle, carrying an event code, the
// oldest held note (zero when the list is empty) and the number of held notes.
// The receiver cannot hold results off; it must take each beat as it appears.
// Status, note-on key and note-on velocity bytes give their result in the
// cycle after acceptance and busy stays low, so such bytes may follow one per
// cycle. A note-off key byte for a non-empty list starts a walk through the
// list memory, with busy high while it runs: the first read is issued, then
// entries are compared in order while searching; a miss ends at the last
// entry, while after a hit each later entry is moved down and a closing step
// lowers the count. The result beat appears in the first cycle in which busy
// is low again. The list lives in a single memory with one write and one
// registered read port; the search and the shift are paced by that read port.
// Reset (i_rst_n low, synchronous) empties the list and returns the byte
// parser to idle; the memory itself is not cleared, as only occupied entries
// are ever read.
module midi_held_note_list_core #(
    parameter int LIST_DEPTH = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_strobe,
    output logic [2:0]           o_event_res,
    output logic [7:0]           o_head_key,
    output logic [7:0]           o_head_velocity,
    output logic [3:0]           o_held_count
);

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    // Sequencer states: the first four follow the byte parser.
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_ON_KEY  = 3'd1;
    localparam logic [2:0] S_ON_VEL  = 3'd2;
    localparam logic [2:0] S_OFF_KEY = 3'd3;
    localparam logic [2:0] S_SCAN    = 3'd4;
    localparam logic [2:0] S_SHIFT   = 3'd5;

    logic [2:0]            r_state, n_state;
    logic [7:0]            r_key, n_key;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_idx, n_idx;
    logic [CW-1:0]         r_pos, n_pos;
    logic                  r_vld, n_vld;
    mhnl_pkg::t_entry      r_head, n_head;
    logic                  r_strobe, n_strobe;
    mhnl_pkg::t_event      r_event, n_event;

    // List memory and its ports.
    mhnl_pkg::t_entry      r_mem [LIST_DEPTH];
    mhnl_pkg::t_entry      r_rd_data;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    mhnl_pkg::t_entry      wr_data;

    logic                  accept;
    logic                  hit;
    logic [CW+3:0]         count_ext;

    assign accept = start && !busy;
    assign busy   = (r_state == S_SCAN) || (r_state == S_SHIFT);
    assign hit    = r_vld && (r_rd_data.key == r_key);

    // Next-state logic for the parser and the search / shift sequencer.
    always_comb begin
        n_state  = r_state;
        n_key    = r_key;
        n_count  = r_count;
        n_idx    = r_idx;
        n_pos    = r_pos;
        n_vld    = 1'b0;
        n_head   = r_head;
        n_strobe = 1'b0;
        n_event  = mhnl_pkg::EV_NONE;
        rd_en    = 1'b0;
        rd_addr  = r_idx[AW-1:0];
        wr_en    = 1'b0;
        wr_addr  = r_count[AW-1:0];
        wr_data  = '{velocity: i_rx_byte, key: r_key};

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_strobe = 1'b1;
                    if (i_rx_byte == mhnl_pkg::STATUS_NOTE_ON) begin
                        n_state = S_ON_KEY;
                    end else if (i_rx_byte == mhnl_pkg::STATUS_NOTE_OFF) begin
                        n_state = S_OFF_KEY;
                    end
                end
            end
            S_ON_KEY: begin
                if (accept) begin
                    n_strobe = 1'b1;
                    n_key    = i_rx_byte;
                    n_state  = S_ON_VEL;
                end
            end
            S_ON_VEL: begin
                // Append at the tail, or drop the note when the list is full.
                if (accept) begin
                    n_strobe = 1'b1;
                    n_state  = S_IDLE;
                    if (r_count < DEPTH_C) begin
                        wr_en   = 1'b1;
                        n_count = r_count + ONE_C;
                        n_event = mhnl_pkg::EV_ADDED;
                        if (r_count == '0) begin
                            n_head = wr_data;
                        end
                    end else begin
                        n_event = mhnl_pkg::EV_DROPPED;
                    end
                end
            end
            S_OFF_KEY: begin
                if (accept) begin
                    n_key = i_rx_byte;
                    if (r_count == '0) begin
                        n_strobe = 1'b1;
                        n_event  = mhnl_pkg::EV_NOT_FOUND;
                        n_state  = S_IDLE;
                    end else begin
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // One read issued per cycle; the previous read is compared.
                if (r_idx < r_count) begin
                    rd_en = 1'b1;
                    n_idx = r_idx + ONE_C;
                    n_vld = 1'b1;
                end
                n_pos = r_idx;
                if (hit) begin
                    // The read just issued fetches the entry after the hit.
                    n_pos   = r_pos;
                    n_state = S_SHIFT;
                end else if (r_vld && (r_pos == r_count - ONE_C)) begin
                    n_strobe = 1'b1;
                    n_event  = mhnl_pkg::EV_NOT_FOUND;
                    n_state  = S_IDLE;
                end
            end
            S_SHIFT: begin
                // Move entry pos+1 down into pos while fetching pos+2.
                if (r_pos + ONE_C < r_count) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pos[AW-1:0];
                    wr_data = r_rd_data;
                    if (r_pos == '0) begin
                        n_head = r_rd_data;
                    end
                    if (r_idx < r_count) begin
                        rd_en = 1'b1;
                        n_idx = r_idx + ONE_C;
                    end
                    n_pos = r_pos + ONE_C;
                end else begin
                    n_count  = r_count - ONE_C;
                    n_strobe = 1'b1;
                    n_event  = mhnl_pkg::EV_REMOVED;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_vld    <= 1'b0;
            r_strobe <= 1'b0;
            r_key    <= '0;
            r_idx    <= '0;
            r_pos    <= '0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_vld    <= n_vld;
            r_strobe <= n_strobe;
            r_key    <= n_key;
            r_idx    <= n_idx;
            r_pos    <= n_pos;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_head  <= n_head;
        r_event <= n_event;
    end

    // List memory: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // Result beat; the list fields are stable until the next accepted byte.
    assign count_ext       = {4'b0000, r_count};
    assign o_strobe        = r_strobe;
    assign o_event_res     = r_event;
    assign o_head_key      = (r_count != '0) ? r_head.key : 8'h00;
    assign o_head_velocity = (r_count != '0) ? r_head.velocity : 8'h00;
    assign o_held_count    = count_ext[3:0];

endmodule

[rtl/mhnl_checker.sv]
// Port-level checks for the held-note list core, bound into the core module.
module mhnl_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       busy,
    input logic       o_strobe,
    input logic [2:0] o_event_res,
    input logic [3:0] o_held_count
);

    // A result beat never appears while a search is still running.
    a_strobe_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result beat while busy");

    // Only defined event codes are reported.
    a_event_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_event_res == mhnl_pkg::EV_NONE ||
                      o_event_res == mhnl_pkg::EV_ADDED ||
                      o_event_res == mhnl_pkg::EV_DROPPED ||
                      o_event_res == mhnl_pkg::EV_REMOVED ||
                      o_event_res == mhnl_pkg::EV_NOT_FOUND))
        else $error("undefined event code");

    // An added note raises the count by one.
    a_added_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_event_res == mhnl_pkg::EV_ADDED && $past(i_rst_n)) |->
            (o_held_count == 4'($past(o_held_count) + 4'd1)))
        else $error("count not raised by added note");

    // A removal lowers the count by one.
    a_removed_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_event_res == mhnl_pkg::EV_REMOVED && $past(i_rst_n)) |->
            (o_held_count == 4'($past(o_held_count) - 4'd1)))
        else $error("count not lowered by removal");

    // Events that leave the list alone keep the count.
    a_count_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(i_rst_n) &&
         (o_event_res == mhnl_pkg::EV_NONE ||
          o_event_res == mhnl_pkg::EV_DROPPED ||
          o_event_res == mhnl_pkg::EV_NOT_FOUND)) |-> $stable(o_held_count))
        else $error("count changed without add or remove");

endmodule

bind midi_held_note_list_core mhnl_checker u_mhnl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_event_res  (o_event_res),
    .o_held_count (o_held_count)
);
